// ===== rtl/core/tes_pkg.sv =====
// ----------------------------------------------------------------------------
// tes_pkg - shared types and constants for the timed event scheduler
// Sizes of the slot store, field widths, request and status codes.
// ----------------------------------------------------------------------------
package tes_pkg;

  // store geometry and field widths
  localparam int SLOTS    = 64;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int TIME_W   = 48;
  localparam int TAG_W    = 16;
  localparam int HANDLE_W = 6;
  localparam int STATUS_W = 3;
  localparam int REQ_W    = 2;

  typedef logic [TIME_W-1:0]   time_t;
  typedef logic [TAG_W-1:0]    tag_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [REQ_W-1:0]    req_t;

  // one stored event
  typedef struct packed {
    logic  to_flag;
    tag_t  tag;
    time_t due_time;
  } slot_ent_t;

  localparam int ENT_W = $bits(slot_ent_t);

  // request codes
  localparam req_t REQ_SUBMIT = 2'd0;
  localparam req_t REQ_NEXT   = 2'd1;
  localparam req_t REQ_CANCEL = 2'd2;
  localparam req_t REQ_CLEAR  = 2'd3;

  // status codes
  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_PAST       = 3'd1;
  localparam status_t ST_EMPTY      = 3'd2;
  localparam status_t ST_FULL       = 3'd3;
  localparam status_t ST_BAD_HANDLE = 3'd4;

endpackage

// ===== rtl/core/timed_event_scheduler.sv =====
// ----------------------------------------------------------------------------
// timed_event_scheduler - discrete event store with timeout cancel
// Holds up to SLOTS timed events; submit, take next, cancel and clear
// requests, one result word per request.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | req_type, event_time, class,
//           |           |                     | action_tag, slot_handle
//   out_    | output    | out_valid/out_ready | status, handle, tag, time,
//           |           |                     | fired_timeout
//
// A next request walks all SLOTS entries through the one RAM read port and
// one comparator. A submit scans the live bits one per cycle for the lowest
// free slot. Reset empties the store and zeroes the clock at once; no
// clearing pass. A stalled result word holds in the output register; a new
// request may be accepted meanwhile and its result waits in the pending
// result registers for the output.
// ----------------------------------------------------------------------------
module timed_event_scheduler (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tes_pkg::req_t    in_req_type,
  input  tes_pkg::time_t   in_event_time,
  input  logic             in_timeout_class,
  input  tes_pkg::tag_t    in_action_tag,
  input  tes_pkg::handle_t in_slot_handle,
  output logic             out_valid,
  input  logic             out_ready,
  output tes_pkg::status_t out_status,
  output tes_pkg::handle_t out_given_handle,
  output tes_pkg::tag_t    out_fired_tag,
  output tes_pkg::time_t   out_now_time,
  output logic             out_fired_timeout
);
  import tes_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAST = 3'd1;
  localparam logic [2:0] S_FREE = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_NFIN = 3'd4;
  localparam logic [2:0] S_CCHK = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam idx_t LAST_IDX = idx_t'(SLOTS - 1);

  logic [2:0]       state_r, state_nxt;
  logic [SLOTS-1:0] live_r, live_nxt;
  time_t            clock_r, clock_nxt;
  idx_t             cnt_r, cnt_nxt;
  logic             issue_done_r, issue_done_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  idx_t             rd_idx_r, rd_idx_nxt;

  // best candidate of a next scan
  logic             found_r, found_nxt;
  idx_t             best_idx_r, best_idx_nxt;
  time_t            best_time_r, best_time_nxt;
  tag_t             best_tag_r, best_tag_nxt;
  logic             best_to_r, best_to_nxt;

  // latched request
  time_t            req_time_r, req_time_nxt;
  tag_t             req_tag_r, req_tag_nxt;
  logic             req_to_r, req_to_nxt;
  idx_t             req_idx_r, req_idx_nxt;
  logic             req_hok_r, req_hok_nxt;

  // pending result
  status_t          res_status_r, res_status_nxt;
  idx_t             res_idx_r, res_idx_nxt;
  tag_t             res_tag_r, res_tag_nxt;
  logic             res_to_r, res_to_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  handle_t          out_handle_r, out_handle_nxt;
  tag_t             out_tag_r, out_tag_nxt;
  time_t            out_time_r, out_time_nxt;
  logic             out_to_r, out_to_nxt;

  // RAM and comparator hookup
  logic             ram_we;
  idx_t             ram_waddr;
  slot_ent_t        ram_wdata;
  idx_t             ram_raddr;
  slot_ent_t        ram_rdata;
  logic [ENT_W-1:0] ram_rdata_raw;
  time_t            cmp_a_time;
  logic             cmp_a_to;
  time_t            cmp_b_time;
  logic             cmp_b_to;
  logic             cmp_first;
  logic             in_fire;

  tes_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = slot_ent_t'(ram_rdata_raw);

  tes_cmp u_cmp (
    .a_time  (cmp_a_time),
    .a_to    (cmp_a_to),
    .b_time  (cmp_b_time),
    .b_to    (cmp_b_to),
    .a_first (cmp_first)
  );

  // comparator operands: scan entry vs best, or submit time vs clock
  always_comb begin
    if (state_r == S_SCAN) begin
      cmp_a_time = ram_rdata.due_time;
      cmp_a_to   = ram_rdata.to_flag;
      cmp_b_time = best_time_r;
      cmp_b_to   = best_to_r;
    end else begin
      cmp_a_time = req_time_r;
      cmp_a_to   = 1'b0;
      cmp_b_time = clock_r;
      cmp_b_to   = 1'b0;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign ram_raddr = (state_r == S_SCAN) ? cnt_r : idx_t'(in_slot_handle);
  assign ram_waddr = cnt_r;
  assign ram_wdata = '{to_flag: req_to_r, tag: req_tag_r, due_time: req_time_r};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    live_nxt       = live_r;
    clock_nxt      = clock_r;
    cnt_nxt        = cnt_r;
    issue_done_nxt = issue_done_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_time_nxt  = best_time_r;
    best_tag_nxt   = best_tag_r;
    best_to_nxt    = best_to_r;
    req_time_nxt   = req_time_r;
    req_tag_nxt    = req_tag_r;
    req_to_nxt     = req_to_r;
    req_idx_nxt    = req_idx_r;
    req_hok_nxt    = req_hok_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_tag_nxt    = res_tag_r;
    res_to_nxt     = res_to_r;
    ram_we         = 1'b0;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_tag_nxt    = out_tag_r;
    out_time_nxt   = out_time_r;
    out_to_nxt     = out_to_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_time_nxt   = in_event_time;
          req_tag_nxt    = in_action_tag;
          req_to_nxt     = in_timeout_class;
          req_idx_nxt    = idx_t'(in_slot_handle);
          req_hok_nxt    = (32'(in_slot_handle) < 32'(SLOTS));
          res_status_nxt = ST_OK;
          res_idx_nxt    = '0;
          res_tag_nxt    = '0;
          res_to_nxt     = 1'b0;
          cnt_nxt        = '0;
          issue_done_nxt = 1'b0;
          found_nxt      = 1'b0;
          case (in_req_type)
            REQ_SUBMIT: state_nxt = S_PAST;
            REQ_NEXT:   state_nxt = S_SCAN;
            REQ_CANCEL: state_nxt = S_CCHK;
            default: begin
              // clear all
              live_nxt  = '0;
              clock_nxt = '0;
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      // refuse a fire time before the clock
      S_PAST: begin
        if (cmp_first) begin
          res_status_nxt = ST_PAST;
          state_nxt      = S_OUT;
        end else begin
          state_nxt = S_FREE;
        end
      end

      // lowest free slot, one live bit per cycle
      S_FREE: begin
        if (!live_r[cnt_r]) begin
          ram_we          = 1'b1;
          live_nxt[cnt_r] = 1'b1;
          res_idx_nxt     = cnt_r;
          state_nxt       = S_OUT;
        end else if (cnt_r == LAST_IDX) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_OUT;
        end else begin
          cnt_nxt = cnt_r + idx_t'(1);
        end
      end

      // walk the store: issue a read per cycle, judge the word in the next cycle
      S_SCAN: begin
        if (!issue_done_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r;
          if (cnt_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + idx_t'(1);
          end
        end
        if (rd_vld_r) begin
          if (live_r[rd_idx_r] && (!found_r || cmp_first)) begin
            found_nxt     = 1'b1;
            best_idx_nxt  = rd_idx_r;
            best_time_nxt = ram_rdata.due_time;
            best_tag_nxt  = ram_rdata.tag;
            best_to_nxt   = ram_rdata.to_flag;
          end
          if (rd_idx_r == LAST_IDX) begin
            state_nxt = S_NFIN;
          end
        end
      end

      // fire the earliest event; live times never lie before the clock
      S_NFIN: begin
        if (found_r) begin
          live_nxt[best_idx_r] = 1'b0;
          clock_nxt            = best_time_r;
          res_idx_nxt          = best_idx_r;
          res_tag_nxt          = best_tag_r;
          res_to_nxt           = best_to_r;
        end else begin
          res_status_nxt = ST_EMPTY;
        end
        state_nxt = S_OUT;
      end

      // cancel: slot word read during the accept cycle
      S_CCHK: begin
        if (req_hok_r && live_r[req_idx_r] && ram_rdata.to_flag) begin
          live_nxt[req_idx_r] = 1'b0;
        end else begin
          res_status_nxt = ST_BAD_HANDLE;
        end
        state_nxt = S_OUT;
      end

      // hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_handle_nxt = handle_t'(res_idx_r);
          out_tag_nxt    = res_tag_r;
          out_time_nxt   = clock_r;
          out_to_nxt     = res_to_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    issue_done_r <= issue_done_nxt;
    rd_idx_r     <= rd_idx_nxt;
    found_r      <= found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_time_r  <= best_time_nxt;
    best_tag_r   <= best_tag_nxt;
    best_to_r    <= best_to_nxt;
    req_time_r   <= req_time_nxt;
    req_tag_r    <= req_tag_nxt;
    req_to_r     <= req_to_nxt;
    req_idx_r    <= req_idx_nxt;
    req_hok_r    <= req_hok_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_tag_r    <= res_tag_nxt;
    res_to_r     <= res_to_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_tag_r    <= out_tag_nxt;
    out_time_r   <= out_time_nxt;
    out_to_r     <= out_to_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_given_handle  = out_handle_r;
  assign out_fired_tag     = out_tag_r;
  assign out_now_time      = out_time_r;
  assign out_fired_timeout = out_to_r;

endmodule

// ===== rtl/core/tes_ram.sv =====
// ----------------------------------------------------------------------------
// tes_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/tes_cmp.sv =====
// ----------------------------------------------------------------------------
// tes_cmp - shared event order comparator
// Tells whether event a fires strictly before event b: earlier time first,
// on equal times a timeout goes ahead of an ordinary event.
// ----------------------------------------------------------------------------
module tes_cmp (
  input  tes_pkg::time_t a_time,
  input  logic           a_to,
  input  tes_pkg::time_t b_time,
  input  logic           b_to,
  output logic           a_first
);
  import tes_pkg::*;

  logic lt;
  logic eq;

  // one wide magnitude compare plus the class tie break
  assign lt      = (a_time < b_time);
  assign eq      = (a_time == b_time);
  assign a_first = lt | (eq & a_to & ~b_to);

endmodule

// ===== bench/timed_event_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// timed_event_scheduler_tb - self-checking bench for the timed event scheduler
// Sends submit, next, cancel and clear requests over the valid/ready input.
// A scoreboard keeps its own copy of the slot store and the simulation clock,
// predicts one result word per accepted request and checks the words in order.
// The run goes through no idling, sender idling, receiver stalls and both, and
// one long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module timed_event_scheduler_tb;
  import tes_pkg::*;

  localparam time_t LATEST      = {TIME_W{1'b1}};
  localparam int    PHASES      = 5;
  localparam int    PHASE_ITEMS = 375;
  localparam int    HOLD_CYCLES = 600;
  localparam int    BURST_LEN   = 80;

  // one result word as the block reports it
  typedef struct {
    status_t status;
    handle_t handle;
    tag_t    tag;
    time_t   now;
    logic    fired_to;
  } sched_word_t;

  // shadow of the slot store; predicts and checks result words
  class event_store_scoreboard;
    bit          live [SLOTS];
    time_t       fire_at [SLOTS];
    tag_t        tag_of [SLOTS];
    bit          is_to [SLOTS];
    time_t       clock_now;
    sched_word_t expected_words [$];
    int          errors;

    function new();
      foreach (live[k]) begin
        live[k]    = 1'b0;
        fire_at[k] = '0;
        tag_of[k]  = '0;
        is_to[k]   = 1'b0;
      end
      clock_now = '0;
      errors    = 0;
    endfunction

    // firing order: time, then timeout class, then lower slot
    function bit fires_ahead(int a, int b);
      if (fire_at[a] != fire_at[b]) return fire_at[a] < fire_at[b];
      if (is_to[a] != is_to[b]) return is_to[a];
      return a < b;
    endfunction

    // apply one accepted request to the shadow store and queue its word
    function void predict_word(req_t req, time_t t, logic cls, tag_t tg, handle_t h);
      sched_word_t w;
      int          pick;
      int          i;
      w.status   = ST_OK;
      w.handle   = '0;
      w.tag      = '0;
      w.fired_to = 1'b0;
      pick       = -1;
      case (req)
        REQ_SUBMIT: begin
          if (t < clock_now) begin
            w.status = ST_PAST;
          end else begin
            for (i = 0; i < SLOTS && pick < 0; i++)
              if (!live[i]) pick = i;
            if (pick < 0) begin
              w.status = ST_FULL;
            end else begin
              live[pick]    = 1'b1;
              fire_at[pick] = t;
              tag_of[pick]  = tg;
              is_to[pick]   = cls;
              w.handle      = handle_t'(pick);
            end
          end
        end
        REQ_NEXT: begin
          for (i = 0; i < SLOTS; i++)
            if (live[i] && (pick < 0 || fires_ahead(i, pick))) pick = i;
          if (pick < 0) begin
            w.status = ST_EMPTY;
          end else begin
            live[pick] = 1'b0;
            if (fire_at[pick] > clock_now) clock_now = fire_at[pick];
            w.handle   = handle_t'(pick);
            w.tag      = tag_of[pick];
            w.fired_to = is_to[pick];
          end
        end
        REQ_CANCEL: begin
          if (!live[h] || !is_to[h]) w.status = ST_BAD_HANDLE;
          else live[h] = 1'b0;
        end
        default: begin
          foreach (live[k]) live[k] = 1'b0;
          clock_now = '0;
        end
      endcase
      w.now = clock_now;
      expected_words.push_back(w);
    endfunction

    // compare one result word with the oldest prediction
    function void check_word(status_t s, handle_t h, tag_t tg, time_t n, logic f);
      sched_word_t w;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: status %0d handle %0d tag %h time %h timeout %b",
                   s, h, tg, n, f);
        return;
      end
      w = expected_words.pop_front();
      if (w.status !== s || w.handle !== h || w.tag !== tg || w.now !== n ||
          w.fired_to !== f) begin
        errors++;
        if (errors <= 10) begin
          $display("word mismatch: expected status %0d handle %0d tag %h time %h timeout %b",
                   w.status, w.handle, w.tag, w.now, w.fired_to);
          $display("               got      status %0d handle %0d tag %h time %h timeout %b",
                   s, h, tg, n, f);
        end
      end
    endfunction

    // a random live timeout slot, or the fallback if there is none
    function handle_t live_timeout(handle_t fallback);
      int hits [$];
      int i;
      for (i = 0; i < SLOTS; i++)
        if (live[i] && is_to[i]) hits.push_back(i);
      if (hits.size() == 0) return fallback;
      return handle_t'(hits[$urandom_range(hits.size() - 1)]);
    endfunction
  endclass

  logic    clk               = 1'b0;
  logic    rst_n             = 1'b0;
  logic    in_valid          = 1'b0;
  logic    in_ready;
  req_t    in_req_type       = REQ_SUBMIT;
  time_t   in_event_time     = '0;
  logic    in_timeout_class  = 1'b0;
  tag_t    in_action_tag     = '0;
  handle_t in_slot_handle    = '0;
  logic    out_valid;
  logic    out_ready         = 1'b0;
  status_t out_status;
  handle_t out_given_handle;
  tag_t    out_fired_tag;
  time_t   out_now_time;
  logic    out_fired_timeout;

  logic    hold_off          = 1'b0;
  logic    pressure_go       = 1'b0;
  int      sender_idle_pct   = 0;
  int      recv_stall_pct    = 0;
  int      burst_left        = 0;
  bit      burst_fill        = 1'b0;

  event_store_scoreboard sb = new();

  always #1 clk = ~clk;

  timed_event_scheduler DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_event_time     (in_event_time),
    .in_timeout_class  (in_timeout_class),
    .in_action_tag     (in_action_tag),
    .in_slot_handle    (in_slot_handle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_given_handle  (out_given_handle),
    .out_fired_tag     (out_fired_tag),
    .out_now_time      (out_now_time),
    .out_fired_timeout (out_fired_timeout)
  );

  // offer one request word, idling first at the current rate
  task automatic send_word(req_t req, time_t t, logic cls, tag_t tg, handle_t h);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_event_time    <= t;
    in_timeout_class <= cls;
    in_action_tag    <= tg;
    in_slot_handle   <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_word(req, t, cls, tg, h);
  endtask

  // fire time around the current clock: exact, past, far, near the top
  function automatic time_t pick_due_time();
    int unsigned     roll;
    logic [TIME_W:0] ahead;
    time_t           back;
    roll = $urandom_range(99);
    if (roll < 8) return sb.clock_now;
    if (roll < 18 && sb.clock_now != 0) begin
      back = time_t'($urandom_range(50, 1));
      if (back > sb.clock_now) back = sb.clock_now;
      return sb.clock_now - back;
    end
    if (roll < 24) return time_t'({$urandom, $urandom});
    if (roll < 28) return LATEST - time_t'($urandom_range(15, 0));
    ahead = sb.clock_now + $urandom_range(40, 0);
    return ahead[TIME_W] ? LATEST : ahead[TIME_W-1:0];
  endfunction

  // one random request; now and then a run of submits to fill the store
  // or a run of next requests to drain it
  task automatic issue_random();
    int unsigned roll;
    req_t        req;
    handle_t     h;
    if (burst_left == 0 && $urandom_range(59) == 0) begin
      burst_left = BURST_LEN;
      burst_fill = bit'($urandom_range(1));
    end
    if (burst_left != 0) begin
      burst_left--;
      req = burst_fill ? REQ_SUBMIT : REQ_NEXT;
    end else begin
      roll = $urandom_range(99);
      if (roll < 45)      req = REQ_SUBMIT;
      else if (roll < 78) req = REQ_NEXT;
      else if (roll < 98) req = REQ_CANCEL;
      else                req = REQ_CLEAR;
    end
    h = handle_t'($urandom_range(63));
    if (req == REQ_CANCEL && $urandom_range(99) < 65) h = sb.live_timeout(h);
    send_word(req, pick_due_time(), logic'($urandom_range(1)), tag_t'($urandom), h);
  endtask

  // receiver: check on each handshake, stall at the current rate
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_word(out_status, out_given_handle, out_fired_tag, out_now_time,
                      out_fired_timeout);
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (pressure_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int idle_of [PHASES];
    int stall_of [PHASES];
    int p;
    idle_of  = '{0, 85, 0, 17, 0};
    stall_of = '{0, 0, 85, 17, 0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty store, bad handles, ties, past and exact times, extremes
    send_word(REQ_NEXT,   LATEST,      1'b1, 16'hFFFF, 6'd63);
    send_word(REQ_CANCEL, '0,          1'b0, 16'h0000, 6'd63);
    send_word(REQ_SUBMIT, '0,          1'b0, 16'h0000, 6'd0);
    send_word(REQ_SUBMIT, LATEST,      1'b1, 16'hFFFF, 6'd63);
    send_word(REQ_SUBMIT, 48'd5,       1'b0, 16'h1111, 6'd0);
    send_word(REQ_SUBMIT, 48'd5,       1'b1, 16'h2222, 6'd0);
    send_word(REQ_SUBMIT, 48'd5,       1'b0, 16'h3333, 6'd0);
    send_word(REQ_CANCEL, '0,          1'b0, 16'h0000, 6'd2);
    send_word(REQ_CANCEL, '0,          1'b0, 16'h0000, 6'd1);
    send_word(REQ_CANCEL, '0,          1'b0, 16'h0000, 6'd1);
    send_word(REQ_NEXT,   '0,          1'b0, 16'h0000, 6'd0);
    send_word(REQ_NEXT,   '0,          1'b0, 16'h0000, 6'd0);
    send_word(REQ_NEXT,   '0,          1'b0, 16'h0000, 6'd0);
    send_word(REQ_SUBMIT, 48'd4,       1'b1, 16'h4444, 6'd0);
    send_word(REQ_SUBMIT, 48'd5,       1'b1, 16'h5555, 6'd0);
    send_word(REQ_NEXT,   '0,          1'b0, 16'h0000, 6'd0);
    send_word(REQ_NEXT,   '0,          1'b0, 16'h0000, 6'd0);
    send_word(REQ_NEXT,   '0,          1'b0, 16'h0000, 6'd0);
    send_word(REQ_SUBMIT, LATEST,      1'b0, 16'h8001, 6'd0);
    send_word(REQ_NEXT,   '0,          1'b0, 16'h0000, 6'd0);
    send_word(REQ_SUBMIT, LATEST - 1,  1'b0, 16'h0001, 6'd0);
    send_word(REQ_SUBMIT, LATEST,      1'b1, 16'h7FFE, 6'd0);
    send_word(REQ_CLEAR,  LATEST,      1'b1, 16'hFFFF, 6'd63);
    send_word(REQ_NEXT,   '0,          1'b0, 16'h0000, 6'd0);
    send_word(REQ_SUBMIT, 48'h5555_5555_5555, 1'b1, 16'hAAAA, 6'd21);

    // random phases; the first opens with the long hold-off
    for (p = 0; p < PHASES; p++) begin
      sender_idle_pct = idle_of[p];
      recv_stall_pct  = stall_of[p];
      if (p == 0) pressure_go <= 1'b1;
      repeat (PHASE_ITEMS) issue_random();
    end
    in_valid <= 1'b0;

    // drain, then watch for stray words
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tes_pkg.sv
rtl/core/tes_ram.sv
rtl/core/tes_cmp.sv
rtl/core/timed_event_scheduler.sv
bench/timed_event_scheduler_tb.sv
